/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the list table engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLTE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define PLTE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/core/plte_pkg.sv */
// ----------------------------------------------------------------------------
// List table engine package
// Field widths, command and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package plte_pkg;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_SEARCH  = 2'd2,
    CMD_REVERSE = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS,
    S_REM,
    S_SRCH,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETUP,
    OP_REJECT,
    OP_INS_STEP,
    OP_INS_PUT,
    OP_REM_STEP,
    OP_REM_DROP,
    OP_SRCH_STEP,
    OP_SRCH_HIT,
    OP_SRCH_MISS,
    OP_REV_RD_LO,
    OP_REV_RD_HI,
    OP_REV_WR_LO,
    OP_REV_WR_HI
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic reject;
    logic ins_done;
    logic rem_done;
    logic srch_hit;
    logic srch_end;
    logic rev_done;
  } sts_t;

endpackage

/* rtl/core/plte_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/plte_datapath.sv */
// ----------------------------------------------------------------------------
// List table datapath
// Holds the entry memory, the count, the walk indices and the result register.
// ----------------------------------------------------------------------------
module plte_datapath #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  plte_pkg::ctl_t                ctl,
  output plte_pkg::sts_t                sts,
  input  plte_pkg::cmd_t                in_cmd,
  input  logic [plte_pkg::POS_W-1:0]    in_position,
  input  logic [plte_pkg::VAL_W-1:0]    in_value,
  output logic [plte_pkg::STAT_W-1:0]   out_status,
  output logic [plte_pkg::IDX_W-1:0]    out_found_index,
  output logic [plte_pkg::CNT_W-1:0]    out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > plte_pkg::POS_W) ? CW : plte_pkg::POS_W;

  plte_pkg::cmd_t                 cmd_q;
  logic [plte_pkg::POS_W-1:0]     pos_q;
  logic [plte_pkg::VAL_W-1:0]     val_q;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  idx;
  logic                           pend;
  logic [AW-1:0]                  tag;
  logic [AW-1:0]                  lo;
  logic [AW-1:0]                  hi;
  logic [plte_pkg::VAL_W-1:0]     tmp;
  plte_pkg::status_t              res_status;
  logic [plte_pkg::IDX_W-1:0]     res_index;

  logic [XW-1:0]                  pos_x;
  logic [XW-1:0]                  cnt_x;
  logic [CW-1:0]                  pos_c;
  logic [CW-1:0]                  idx_inc;
  logic                           full;
  logic                           reject;
  plte_pkg::status_t              err;

  logic                           we;
  logic [AW-1:0]                  waddr;
  logic [plte_pkg::VAL_W-1:0]     wdata;
  logic [AW-1:0]                  raddr;
  logic [plte_pkg::VAL_W-1:0]     rdata;

  plte_ram #(
    .WIDTH (plte_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pos_x   = XW'(pos_q);
  assign cnt_x   = XW'(count);
  assign pos_c   = CW'(pos_q);
  assign idx_inc = CW'(idx + 1'b1);
  assign full    = (count == CW'(DEPTH));

  always_comb begin
    err    = plte_pkg::ST_OK;
    reject = 1'b0;
    case (cmd_q)
      plte_pkg::CMD_INSERT: begin
        if (full) begin
          err    = plte_pkg::ST_FULL;
          reject = 1'b1;
        end else if (pos_x > cnt_x) begin
          err    = plte_pkg::ST_BAD_POS;
          reject = 1'b1;
        end
      end
      plte_pkg::CMD_REMOVE: begin
        if (pos_x >= cnt_x) begin
          err    = plte_pkg::ST_BAD_POS;
          reject = 1'b1;
        end
      end
      default: begin
        err    = plte_pkg::ST_OK;
        reject = 1'b0;
      end
    endcase
  end

  assign sts.reject   = reject;
  assign sts.cmd      = cmd_q;
  assign sts.ins_done = (idx == pos_c) && !pend;
  assign sts.rem_done = (idx_inc >= count) && !pend;
  assign sts.srch_hit = pend && (rdata == val_q);
  assign sts.srch_end = !pend && (idx >= count);
  assign sts.rev_done = (lo >= hi);

  always_comb begin
    we    = 1'b0;
    waddr = tag;
    wdata = rdata;
    raddr = '0;
    unique case (ctl.op)
      plte_pkg::OP_INS_STEP: begin
        we    = pend;
        raddr = AW'(idx - 1'b1);
      end
      plte_pkg::OP_INS_PUT: begin
        we    = 1'b1;
        waddr = AW'(pos_c);
        wdata = val_q;
      end
      plte_pkg::OP_REM_STEP: begin
        we    = pend;
        raddr = AW'(idx_inc);
      end
      plte_pkg::OP_SRCH_STEP: begin
        raddr = AW'(idx);
      end
      plte_pkg::OP_REV_RD_LO: begin
        raddr = lo;
      end
      plte_pkg::OP_REV_RD_HI: begin
        raddr = hi;
      end
      plte_pkg::OP_REV_WR_LO: begin
        we    = 1'b1;
        waddr = lo;
      end
      plte_pkg::OP_REV_WR_HI: begin
        we    = 1'b1;
        waddr = hi;
        wdata = tmp;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // The pending flag marks read data to write back, or to compare, in this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      count <= '0;
    end else begin
      case (ctl.op)
        plte_pkg::OP_SETUP:     pend  <= 1'b0;
        plte_pkg::OP_INS_STEP:  pend  <= (idx > pos_c);
        plte_pkg::OP_INS_PUT:   count <= CW'(count + 1'b1);
        plte_pkg::OP_REM_STEP:  pend  <= (idx_inc < count);
        plte_pkg::OP_REM_DROP:  count <= CW'(count - 1'b1);
        plte_pkg::OP_SRCH_STEP: pend  <= (idx < count);
        plte_pkg::OP_SRCH_HIT:  pend  <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      plte_pkg::OP_LATCH: begin
        cmd_q <= in_cmd;
        pos_q <= in_position;
        val_q <= in_value;
      end
      plte_pkg::OP_SETUP: begin
        res_status <= plte_pkg::ST_OK;
        res_index  <= '0;
        case (cmd_q)
          plte_pkg::CMD_INSERT: idx <= count;
          plte_pkg::CMD_REMOVE: idx <= pos_c;
          plte_pkg::CMD_SEARCH: idx <= '0;
          default: begin
            lo <= '0;
            hi <= (count >= CW'(2)) ? AW'(count - 1'b1) : '0;
          end
        endcase
      end
      plte_pkg::OP_REJECT: begin
        res_status <= err;
        res_index  <= '0;
      end
      plte_pkg::OP_INS_STEP: begin
        if (idx > pos_c) begin
          tag <= AW'(idx);
          idx <= CW'(idx - 1'b1);
        end
      end
      plte_pkg::OP_REM_STEP: begin
        if (idx_inc < count) begin
          tag <= AW'(idx);
          idx <= idx_inc;
        end
      end
      plte_pkg::OP_SRCH_STEP: begin
        if (idx < count) begin
          tag <= AW'(idx);
          idx <= idx_inc;
        end
      end
      plte_pkg::OP_SRCH_HIT: begin
        res_index <= plte_pkg::IDX_W'(tag);
      end
      plte_pkg::OP_SRCH_MISS: begin
        res_status <= plte_pkg::ST_NOT_FOUND;
      end
      plte_pkg::OP_REV_RD_HI: begin
        tmp <= rdata;
      end
      plte_pkg::OP_REV_WR_HI: begin
        lo <= AW'(lo + 1'b1);
        hi <= AW'(hi - 1'b1);
      end
      default: begin
      end
    endcase
    if (ctl.out_load) begin
      out_status      <= res_status;
      out_found_index <= res_index;
      out_entry_count <= plte_pkg::CNT_W'(count);
    end
  end

endmodule

/* rtl/core/plte_ctrl.sv */
// ----------------------------------------------------------------------------
// List table controller
// Sequences each command through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module plte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output plte_pkg::ctl_t ctl,
  input  plte_pkg::sts_t sts
);

  plte_pkg::state_t state;
  plte_pkg::state_t state_next;
  logic             m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= plte_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    ctl.op       = plte_pkg::OP_NONE;
    ctl.out_load = 1'b0;
    unique case (state)
      plte_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.op     = plte_pkg::OP_LATCH;
          state_next = plte_pkg::S_CHECK;
        end
      end
      plte_pkg::S_CHECK: begin
        if (sts.reject) begin
          ctl.op     = plte_pkg::OP_REJECT;
          state_next = plte_pkg::S_DONE;
        end else begin
          ctl.op = plte_pkg::OP_SETUP;
          unique case (sts.cmd)
            plte_pkg::CMD_INSERT:  state_next = plte_pkg::S_INS;
            plte_pkg::CMD_REMOVE:  state_next = plte_pkg::S_REM;
            plte_pkg::CMD_SEARCH:  state_next = plte_pkg::S_SRCH;
            plte_pkg::CMD_REVERSE: state_next = plte_pkg::S_REV_RD_LO;
          endcase
        end
      end
      plte_pkg::S_INS: begin
        if (sts.ins_done) begin
          ctl.op     = plte_pkg::OP_INS_PUT;
          state_next = plte_pkg::S_DONE;
        end else begin
          ctl.op = plte_pkg::OP_INS_STEP;
        end
      end
      plte_pkg::S_REM: begin
        if (sts.rem_done) begin
          ctl.op     = plte_pkg::OP_REM_DROP;
          state_next = plte_pkg::S_DONE;
        end else begin
          ctl.op = plte_pkg::OP_REM_STEP;
        end
      end
      plte_pkg::S_SRCH: begin
        if (sts.srch_hit) begin
          ctl.op     = plte_pkg::OP_SRCH_HIT;
          state_next = plte_pkg::S_DONE;
        end else if (sts.srch_end) begin
          ctl.op     = plte_pkg::OP_SRCH_MISS;
          state_next = plte_pkg::S_DONE;
        end else begin
          ctl.op = plte_pkg::OP_SRCH_STEP;
        end
      end
      plte_pkg::S_REV_RD_LO: begin
        if (sts.rev_done) begin
          state_next = plte_pkg::S_DONE;
        end else begin
          ctl.op     = plte_pkg::OP_REV_RD_LO;
          state_next = plte_pkg::S_REV_RD_HI;
        end
      end
      plte_pkg::S_REV_RD_HI: begin
        ctl.op     = plte_pkg::OP_REV_RD_HI;
        state_next = plte_pkg::S_REV_WR_LO;
      end
      plte_pkg::S_REV_WR_LO: begin
        ctl.op     = plte_pkg::OP_REV_WR_LO;
        state_next = plte_pkg::S_REV_WR_HI;
      end
      plte_pkg::S_REV_WR_HI: begin
        ctl.op     = plte_pkg::OP_REV_WR_HI;
        state_next = plte_pkg::S_REV_RD_LO;
      end
      plte_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          ctl.out_load = 1'b1;
          state_next   = plte_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plte_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

endmodule

/* rtl/core/positional_list_table_engine.sv */
// ----------------------------------------------------------------------------
// Positional list table engine
// Packed list of signed 32-bit entries with insert, remove, search, reverse.
// ----------------------------------------------------------------------------
// Each command takes one transfer in and gives one transfer out. The entries
// live in a single-port-read RAM, so the insert, remove and search walks move
// one entry per cycle, while a reverse reads the low and the high entry of
// each pair and then writes both back. A rejected command goes straight from
// the check to the done state. A result waits in the done state while the
// previous result still waits at the output. A new command is taken while
// the previous result still waits at the output.
module positional_list_table_engine #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // position [4:0], value [36:5], zero fill [39:37]
  input  logic [plte_pkg::S_TDATA_W-1:0]    s_tdata,
  // cmd [1:0]
  input  logic [plte_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // found_index [4:0], entry_count [10:5], zero fill [15:11]
  output logic [plte_pkg::M_TDATA_W-1:0]    m_tdata,
  // status [1:0]
  output logic [plte_pkg::STAT_W-1:0]       m_tuser
);

  `include "assert_macros.svh"

  plte_pkg::ctl_t               ctl;
  plte_pkg::sts_t               sts;
  logic [plte_pkg::IDX_W-1:0]   found_index;
  logic [plte_pkg::CNT_W-1:0]   entry_count;

  plte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl),
    .sts      (sts)
  );

  plte_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (plte_pkg::cmd_t'(s_tuser)),
    .in_position     (s_tdata[4:0]),
    .in_value        (s_tdata[36:5]),
    .out_status      (m_tuser),
    .out_found_index (found_index),
    .out_entry_count (entry_count)
  );

  assign m_tdata = {5'b0, entry_count, found_index};

  `PLTE_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  `PLTE_ASSERT_IMP(a_no_overwrite, clk, rst, ctl.out_load, !m_tvalid || m_tready)
  `PLTE_ASSERT_IMP(a_reject_on_error, clk, rst, ctl.op == plte_pkg::OP_REJECT, sts.reject)

endmodule

/* tb/positional_list_table_engine_tb.sv */
// ----------------------------------------------------------------------------
// Positional list table engine testbench
// Drives insert, remove, search and reverse commands through the stream
// ports, keeps a shadow copy of the list to predict every result, and checks
// each returned transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module positional_list_table_engine_tb;

  localparam int LIST_DEPTH  = 32;
  localparam int ITEM_TARGET = 1850;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    plte_pkg::status_t status;
    logic [4:0]        idx;
    logic [5:0]        cnt;
  } list_result_t;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_CHURN
  } mix_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [plte_pkg::S_TDATA_W-1:0]     s_tdata = '0;
  logic [plte_pkg::CMD_W-1:0]         s_tuser = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [plte_pkg::M_TDATA_W-1:0]     m_tdata;
  logic [plte_pkg::STAT_W-1:0]        m_tuser;

  logic [31:0]    list_shadow [LIST_DEPTH];
  int             list_len = 0;
  list_result_t   pending_results [$];
  int             fail_count = 0;
  int             cmds_sent = 0;
  int             burst_left = 0;
  int             idle_cycles = 0;
  int             rx_cycle = 0;
  int             rx_mode = 0;
  int             rx_hold = 0;

  positional_list_table_engine #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // Updates the shadow list for one accepted command and queues its result.
  function automatic void apply_list_cmd(plte_pkg::cmd_t op, logic [4:0] pos,
                                         logic [31:0] val);
    list_result_t r;
    int k;
    logic [31:0] t;
    r.status = plte_pkg::ST_OK;
    r.idx = '0;
    case (op)
      plte_pkg::CMD_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = plte_pkg::ST_FULL;
        end else if (int'(pos) > list_len) begin
          r.status = plte_pkg::ST_BAD_POS;
        end else begin
          for (k = list_len; k > int'(pos); k--) list_shadow[k] = list_shadow[k-1];
          list_shadow[pos] = val;
          list_len++;
        end
      end
      plte_pkg::CMD_REMOVE: begin
        if (int'(pos) >= list_len) begin
          r.status = plte_pkg::ST_BAD_POS;
        end else begin
          for (k = int'(pos); k + 1 < list_len; k++) list_shadow[k] = list_shadow[k+1];
          list_len--;
        end
      end
      plte_pkg::CMD_SEARCH: begin
        r.status = plte_pkg::ST_NOT_FOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_shadow[k] == val) begin
            r.status = plte_pkg::ST_OK;
            r.idx = 5'(k);
            break;
          end
        end
      end
      default: begin
        for (k = 0; k < list_len / 2; k++) begin
          t = list_shadow[k];
          list_shadow[k] = list_shadow[list_len-1-k];
          list_shadow[list_len-1-k] = t;
        end
      end
    endcase
    r.cnt = 6'(list_len);
    pending_results.push_back(r);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_list_cmd(input plte_pkg::cmd_t op, input logic [4:0] pos,
                               input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {3'b000, val, pos};
    do @(posedge clk); while (!s_tready);
    apply_list_cmd(op, pos, val);
    cmds_sent++;
  endtask

  task automatic run_random_cmd(input mix_t mix);
    int roll;
    plte_pkg::cmd_t op;
    logic [4:0] pos;
    logic [31:0] val;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (roll < 75) op = plte_pkg::CMD_INSERT;
        else if (roll < 85) op = plte_pkg::CMD_REMOVE;
        else if (roll < 95) op = plte_pkg::CMD_SEARCH;
        else op = plte_pkg::CMD_REVERSE;
      end
      MIX_SHRINK: begin
        if (roll < 75) op = plte_pkg::CMD_REMOVE;
        else if (roll < 85) op = plte_pkg::CMD_INSERT;
        else if (roll < 95) op = plte_pkg::CMD_SEARCH;
        else op = plte_pkg::CMD_REVERSE;
      end
      default: begin
        if (roll < 30) op = plte_pkg::CMD_INSERT;
        else if (roll < 55) op = plte_pkg::CMD_REMOVE;
        else if (roll < 85) op = plte_pkg::CMD_SEARCH;
        else op = plte_pkg::CMD_REVERSE;
      end
    endcase
    pos = 5'($urandom_range(0, 31));
    val = pick_value();
    if (op == plte_pkg::CMD_INSERT && $urandom_range(0, 9) != 0) begin
      pos = 5'($urandom_range(0, list_len < 31 ? list_len : 31));
    end
    if (op == plte_pkg::CMD_REMOVE && list_len > 0 && $urandom_range(0, 9) != 0) begin
      pos = 5'($urandom_range(0, list_len - 1));
    end
    if (op == plte_pkg::CMD_SEARCH && list_len > 0 && $urandom_range(0, 9) < 6) begin
      val = list_shadow[$urandom_range(0, list_len - 1)];
    end
    push_list_cmd(op, pos, val);
  endtask

  task automatic test_empty_list();
    push_list_cmd(plte_pkg::CMD_REMOVE, 5'd0, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_REMOVE, 5'd31, 32'hFFFF_FFFF);
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd0, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_REVERSE, 5'd0, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd1, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_insert_search();
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd0, 32'h7FFF_FFFF);
    push_list_cmd(plte_pkg::CMD_REVERSE, 5'd0, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd0, 32'h8000_0000);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd2, 32'hFFFF_FFFF);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd1, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd5, 32'h0000_0001);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd2, 32'h7FFF_FFFF);
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd31, 32'h8000_0000);
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd0, 32'hFFFF_FFFF);
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd0, 32'h7FFF_FFFF);
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd0, 32'h1234_5678);
  endtask

  task automatic test_reverse_remove();
    push_list_cmd(plte_pkg::CMD_REVERSE, 5'd17, 32'hFFFF_FFFF);
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd0, 32'h7FFF_FFFF);
    push_list_cmd(plte_pkg::CMD_REMOVE, 5'd5, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_REMOVE, 5'd4, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_REMOVE, 5'd0, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_REVERSE, 5'd0, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_REMOVE, 5'd31, 32'h0000_0000);
  endtask

  // Fills the list to capacity, hits it with full-list commands, then drains it.
  task automatic test_full_list();
    int steps;
    steps = 0;
    while (list_len < LIST_DEPTH && steps < 400) begin
      run_random_cmd(MIX_GROW);
      steps++;
    end
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd0, pick_value());
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd31, pick_value());
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd0, list_shadow[LIST_DEPTH-1]);
    push_list_cmd(plte_pkg::CMD_SEARCH, 5'd0, 32'h5A5A_A5A5);
    push_list_cmd(plte_pkg::CMD_REVERSE, 5'd0, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_REMOVE, 5'd31, 32'h0000_0000);
    push_list_cmd(plte_pkg::CMD_INSERT, 5'd31, pick_value());
    steps = 0;
    while (list_len > 0 && steps < 400) begin
      run_random_cmd(MIX_SHRINK);
      steps++;
    end
  endtask

  task automatic test_random_mix();
    mix_t mix;
    int steps;
    int extra;
    while (cmds_sent < ITEM_TARGET) begin
      mix = mix_t'($urandom_range(0, 2));
      steps = 0;
      extra = $urandom_range(2, 6);
      if (mix == MIX_CHURN) begin
        extra = $urandom_range(20, 90);
      end else begin
        while (cmds_sent < ITEM_TARGET && steps < 150 &&
               (mix == MIX_GROW ? list_len < LIST_DEPTH : list_len > 0)) begin
          run_random_cmd(mix);
          steps++;
        end
      end
      repeat (extra) begin
        if (cmds_sent < ITEM_TARGET) run_random_cmd(mix);
      end
    end
  endtask

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (rx_cycle % 5 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_hold = $urandom_range(1, 16);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0d index %0d count %0d",
                 $time, m_tuser, m_tdata[4:0], m_tdata[10:5]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[4:0] != want.idx) begin
          $display("%0t: found_index expected %0d actual %0d", $time, want.idx, m_tdata[4:0]);
          fail_count++;
        end
        if (m_tdata[10:5] != want.cnt) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.cnt, m_tdata[10:5]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("positional_list_table_engine test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_insert_search();
    test_reverse_remove();
    test_full_list();
    test_random_mix();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_list_table_engine test passed");
    end else begin
      $display("positional_list_table_engine test failed");
    end
    $finish;
  end

endmodule

/* positional_list_table_engine.f */
+incdir+rtl/core
rtl/core/plte_pkg.sv
rtl/core/plte_ram.sv
rtl/core/plte_datapath.sv
rtl/core/plte_ctrl.sv
rtl/core/positional_list_table_engine.sv
tb/positional_list_table_engine_tb.sv
